FILE: design/fas_pkg.sv
// Package: shared constants and command codes for the float32 adder/subtractor.
package fas_pkg;

  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] QNAN_BITS  = 32'h7fc0_0000;
  localparam logic [31:0] INF_BITS   = 32'h7f80_0000;
  localparam logic [24:0] CARRY_LIM  = 25'h100_0000;
  localparam logic [23:0] HIDDEN_BIT = 24'h80_0000;
  localparam int          EXP_BIAS   = 127;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUB = 1'b1;

endpackage

FILE: design/fas_core.sv
// Combinational core: special cases, alignment, add, renormalize and pack.
module fas_core (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum_bits
);

  // Round-half-to-even right shift of a 24-bit significand; n > 23 gives zero.
  function automatic logic [23:0] shr_round(input logic [23:0] v, input logic [8:0] n);
    logic [47:0] wide;
    logic [23:0] q;
    logic [23:0] lost;
    logic [23:0] half;
    logic [23:0] msk;
    begin
      if (n == 9'd0) begin
        shr_round = v;
      end else if (n > 9'd23) begin
        shr_round = '0;
      end else begin
        wide = {v, 24'd0} >> n[4:0];
        q    = wide[47:24];
        msk  = (24'd1 << n[4:0]) - 24'd1;
        lost = v & msk;
        half = 24'd1 << (n[4:0] - 5'd1);
        if (lost > half) shr_round = q + 24'd1;
        else if (lost == half) shr_round = q + {23'd0, q[0]};
        else shr_round = q;
      end
    end
  endfunction

  logic [7:0]  a_ef, b_ef;
  logic        a_sg, b_sg, d_sg;
  logic [23:0] a_m0, b_m0, a_m, b_m;
  logic [24:0] d_m, c_m;
  logic [24:0] r_m;
  logic [8:0]  gap_ab, gap_ba;
  logic signed [9:0] d_e, n_e, f_e;
  logic [4:0]  lz;
  logic [4:0]  sh;
  logic [31:0] arith;

  assign a_ef = a[30:23];
  assign b_ef = b[30:23];
  assign a_sg = a[31];
  assign b_sg = b[31];
  assign a_m0 = (a[30:0] == 31'd0) ? 24'd0 : {1'b1, a[22:0]};
  assign b_m0 = (b[30:0] == 31'd0) ? 24'd0 : {1'b1, b[22:0]};
  assign gap_ab = {1'b0, a_ef} - {1'b0, b_ef};
  assign gap_ba = {1'b0, b_ef} - {1'b0, a_ef};

  always_comb begin
    // align smaller operand to the larger exponent
    a_m = a_m0;
    b_m = b_m0;
    d_e = 10'(signed'({2'b00, b_ef})) - 10'(fas_pkg::EXP_BIAS);
    if (b_ef > a_ef) begin
      a_m = shr_round(a_m0, gap_ba);
    end else if (b_ef < a_ef) begin
      b_m = shr_round(b_m0, gap_ab);
      d_e = 10'(signed'({2'b00, a_ef})) - 10'(fas_pkg::EXP_BIAS);
    end
    // signed magnitude add
    if (a_sg != b_sg) begin
      if (a_m > b_m) begin
        d_m  = {1'b0, a_m - b_m};
        d_sg = a_sg;
      end else begin
        d_m  = {1'b0, b_m - a_m};
        d_sg = b_sg;
      end
    end else begin
      d_m  = {1'b0, a_m} + {1'b0, b_m};
      d_sg = a_sg;
    end
    // leading zero count of the 24-bit significand
    lz = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (d_m[i]) lz = 5'(23 - i);
    end
    // renormalize
    n_e = d_e;
    r_m = d_m;
    sh  = 5'd0;
    if (d_m >= fas_pkg::CARRY_LIM) begin
      c_m = {1'b0, d_m[24:1]};
      if (d_m[0] && c_m[0]) c_m = c_m + 25'd1;
      n_e = d_e + 10'sd1;
      r_m = c_m;
      if (c_m >= fas_pkg::CARRY_LIM) begin
        r_m = {1'b0, c_m[24:1]};
        n_e = d_e + 10'sd2;
      end
    end else begin
      c_m = d_m;
      // shift left at most down to exponent -127
      if (10'(signed'({5'd0, lz})) > d_e + 10'sd127) sh = 5'(d_e + 10'sd127);
      else sh = lz;
      r_m = d_m << sh;
      n_e = d_e - 10'(signed'({5'd0, sh}));
    end
    f_e = n_e + 10'(fas_pkg::EXP_BIAS);
    if (n_e > 10'sd127) arith = {d_sg, 31'd0} | fas_pkg::INF_BITS;
    else arith = {d_sg, f_e[7:0], r_m[22:0]};
    if (d_m == 25'd0) arith = '0;
    // special operands
    if (a_ef == 8'hff) begin
      if (a[22:0] != 23'd0) sum_bits = a;
      else if (b_ef == 8'hff) begin
        if (b[22:0] != 23'd0) sum_bits = b;
        else sum_bits = (a_sg == b_sg) ? b : fas_pkg::QNAN_BITS;
      end else sum_bits = a;
    end else if (b_ef == 8'hff) begin
      sum_bits = b;
    end else begin
      sum_bits = arith;
    end
  end

endmodule

FILE: design/float32_add_sub.sv
// Top level: registered single-precision adder/subtractor with stream channels.
// Usage:
//   Input beats carry cmd (0 add, 1 subtract) and two IEEE-754 single words.
//   Each accepted beat produces exactly one output beat holding the result.
// Pipeline: input register, then result register. Throughput: one beat per
//   cycle while out_tready allows; the combinational core between the two
//   registers lets a new beat enter every cycle when the output is not stalled.
// Backpressure: when out_tready is low, the result register holds its beat
//   and the input stage still accepts one more beat into its register; the
//   input side stalls only when both stages are full.
// Reset: rst_n (synchronous, active low) empties both stages; no data state.
// No configuration registers.
module float32_add_sub (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [0] cmd, [32:1] operand_a, [64:33] operand_b, zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] sum_bits
);

  logic        s1_vld_r, s1_vld_nxt;
  logic [31:0] a_r, b_r;
  logic [31:0] res_r;
  logic        o_vld_r, o_vld_nxt;
  logic [31:0] core_sum;
  logic        adv;

  // stage 2 may load when empty or draining
  assign adv       = !o_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;

  fas_core u_core (.a(a_r), .b(b_r), .sum_bits(core_sum));

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    o_vld_nxt  = o_vld_r;
    if (adv) begin
      o_vld_nxt  = s1_vld_r;
      s1_vld_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) s1_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  // payload registers; subtract flips operand_b sign on entry
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_r <= in_tdata[32:1];
      b_r <= in_tdata[64:33] ^ ((in_tdata[0] == fas_pkg::CMD_SUB) ? fas_pkg::SIGN_BIT : 32'd0);
    end
    if (adv && s1_vld_r) res_r <= core_sum;
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = res_r;

endmodule

FILE: tb/sv/float32_add_sub_tb.sv
// Testbench for the float32 adder/subtractor: stream driver, predictor and scoreboard.
module float32_add_sub_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted sum for one beat, computed from the IEEE bit patterns
  function automatic logic [31:0] fp_shift_round(logic [31:0] v, int unsigned n);
    logic [31:0] lost, half, r;
    if (n == 0) return v;
    if (n > 23) return 32'd0;
    lost = v & ((32'd1 << n) - 1);
    half = 32'd1 << (n - 1);
    r = v >> n;
    if (lost > half) r = r + 1;
    else if (lost == half) r = r + (r & 32'd1);
    return r;
  endfunction

  function automatic logic [31:0] fp_sum(logic cmd, logic [31:0] a, logic [31:0] bin);
    logic [31:0] b, am, bm, dm;
    logic [7:0] aef, bef;
    logic as, bs, ds;
    int ae, be, de;
    b = (cmd == fas_pkg::CMD_SUB) ? (bin ^ fas_pkg::SIGN_BIT) : bin;
    aef = a[30:23];
    bef = b[30:23];
    as = a[31];
    bs = b[31];
    // infinities and NaNs
    if (aef == 8'hff) begin
      if (a[22:0] != 0) return a;
      if (bef == 8'hff) begin
        if (b[22:0] != 0) return b;
        return (as == bs) ? b : fas_pkg::QNAN_BITS;
      end
      return a;
    end
    if (bef == 8'hff) return b;
    ae = int'(aef) - fas_pkg::EXP_BIAS;
    be = int'(bef) - fas_pkg::EXP_BIAS;
    am = (a[30:0] == 0) ? 32'd0 : {8'd0, 1'b1, a[22:0]};
    bm = (b[30:0] == 0) ? 32'd0 : {8'd0, 1'b1, b[22:0]};
    // align the smaller operand
    de = be;
    if (be > ae) am = fp_shift_round(am, be - ae);
    else if (be < ae) begin
      bm = fp_shift_round(bm, ae - be);
      de = ae;
    end
    if (as != bs) begin
      if (am > bm) begin
        dm = am - bm;
        ds = as;
      end else begin
        dm = bm - am;
        ds = bs;
      end
    end else begin
      dm = am + bm;
      ds = as;
    end
    if (dm == 0) return 32'd0;
    // renormalize
    if (dm >= 32'(fas_pkg::CARRY_LIM)) begin
      dm = fp_shift_round(dm, 1);
      de++;
      if (dm >= 32'(fas_pkg::CARRY_LIM)) begin
        dm = dm >> 1;
        de++;
      end
    end else begin
      while (dm < 32'(fas_pkg::HIDDEN_BIT) && de > -fas_pkg::EXP_BIAS) begin
        dm = dm << 1;
        de--;
      end
    end
    if (de > fas_pkg::EXP_BIAS) return {ds, 31'd0} | fas_pkg::INF_BITS;
    return {ds, 8'(de + fas_pkg::EXP_BIAS), dm[22:0]};
  endfunction

  // Scoreboard: queue of predicted sums
  class sum_scoreboard;
    logic [31:0] pending_sums[$];
    int errors = 0;

    function void note_operands(logic cmd, logic [31:0] a, logic [31:0] b);
      pending_sums.push_back(fp_sum(cmd, a, b));
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      if (pending_sums.size() == 0) begin
        $error("sum_bits: unexpected beat, actual %h", got);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        $error("sum_bits: expected %h actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [71:0] in_tdata;   // [0] cmd, [32:1] operand_a, [64:33] operand_b, zeros
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;  // [31:0] sum_bits

  sum_scoreboard sb;
  logic stim_done;
  logic hold_off_req;
  int idle_cycles = 0;

  float32_add_sub i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random operand with bias toward interesting exponents and fractions
  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hff;
      1: v[30:23] = 8'h00;
      2: v[22:0] = ($urandom_range(0, 1) != 0) ? 23'd0 : 23'h7fffff;
      3: v[30:23] = 8'hfe;
      default: ;
    endcase
    return v;
  endfunction

  // Send one beat, waiting for acceptance
  task automatic send_beat(logic cmd, logic [31:0] a, logic [31:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, b, a, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_operands(cmd, a, b);
  endtask

  task automatic send_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    send_beat(fas_pkg::CMD_ADD, a, b);
    send_gap();
    send_beat(fas_pkg::CMD_SUB, a, b);
    send_gap();
  endtask

  // Stimulus
  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] same;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    stim_done = 1'b0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zeros, infinities, NaNs, carry, cancellation, overflow, subnormals
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h7f80_0000, 32'h3f80_0000);
    send_pair(32'h7f80_0000, 32'h7f80_0000);
    send_pair(32'hff80_0000, 32'h7f80_0000);
    send_pair(32'h7fc0_0001, 32'h7f80_0000);
    send_pair(32'h3f80_0000, 32'hffc0_0000);
    send_pair(32'h3f80_0000, 32'h3f80_0000);
    send_pair(32'h7f7f_ffff, 32'h7f7f_ffff);
    send_pair(32'h3f80_0000, 32'h3380_0000);
    send_pair(32'h3f80_0000, 32'h3300_0000);
    send_pair(32'h0000_0001, 32'h0080_0000);
    send_pair(32'h3fff_ffff, 32'h3f80_0001);
    send_beat(fas_pkg::CMD_ADD, 32'hffff_ffff, 32'hffff_ffff);
    // sender pauses until the pipeline drains
    in_tvalid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    // receiver holds off while the sender keeps offering
    hold_off_req <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_beat(1'($urandom_range(0, 1)), rand_operand(), rand_operand());
    end
    hold_off_req <= 1'b0;
    // random beats, often with near-equal magnitudes to exercise cancellation
    for (int i = 0; i < 1000; i++) begin
      a = rand_operand();
      b = rand_operand();
      if ($urandom_range(0, 3) == 0) begin
        same = a;
        b = {$urandom_range(0, 1) != 0, same[30:23], same[22:0] ^ 23'($urandom_range(0, 7))};
      end
      send_beat(1'($urandom_range(0, 1)), a, b);
      if ($urandom_range(0, 4) != 0) send_gap();
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver: random stalls plus long hold-offs while hold_off_req is set
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sum(out_tdata);
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    fork
      begin
        wait (stim_done);
        while (sb.pending_sums.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
      end
      begin
        wait (idle_cycles >= 2000);
        sb.errors++;
        $display("watchdog: no beat for %0d cycles", idle_cycles);
      end
    join_any
    if (sb.errors == 0) begin
      $display("float32_add_sub_tb: clean");
    end else begin
      $display("float32_add_sub_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/fas_pkg.sv
design/fas_core.sv
design/float32_add_sub.sv
tb/sv/float32_add_sub_tb.sv
